// ===== src/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define SST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define SST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

// ===== src/sst_pkg.sv =====
// Types, constants and character helpers of the style-sheet tokenizer.
`default_nettype none
package sst_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 5;
    localparam int POS_W   = 16;
    localparam int LEN_W   = 12;
    localparam int KWI_W   = 4;
    localparam int MODE_W  = 3;
    localparam int GRP_MAX = 4;
    localparam int CNT_W   = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [POS_W-1:0] POS_CAP = 16'hFFFF;
    localparam logic [LEN_W-1:0] LEN_CAP = 12'hFFF;

    localparam logic [MODE_W-1:0] M_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] M_IDENT  = 3'd1;
    localparam logic [MODE_W-1:0] M_NUMBER = 3'd2;
    localparam logic [MODE_W-1:0] M_STRING = 3'd3;
    localparam logic [MODE_W-1:0] M_OP     = 3'd4;
    localparam logic [MODE_W-1:0] M_BANG   = 3'd5;

    localparam logic [KIND_W-1:0] K_HASH        = 5'd0;
    localparam logic [KIND_W-1:0] K_DOT         = 5'd1;
    localparam logic [KIND_W-1:0] K_LBRACK      = 5'd2;
    localparam logic [KIND_W-1:0] K_RBRACK      = 5'd3;
    localparam logic [KIND_W-1:0] K_LBRACE      = 5'd4;
    localparam logic [KIND_W-1:0] K_RBRACE      = 5'd5;
    localparam logic [KIND_W-1:0] K_EQ          = 5'd6;
    localparam logic [KIND_W-1:0] K_STAR_EQ     = 5'd7;
    localparam logic [KIND_W-1:0] K_TILDE_EQ    = 5'd8;
    localparam logic [KIND_W-1:0] K_CARET_EQ    = 5'd9;
    localparam logic [KIND_W-1:0] K_PIPE_EQ     = 5'd10;
    localparam logic [KIND_W-1:0] K_DOLLAR_EQ   = 5'd11;
    localparam logic [KIND_W-1:0] K_EQ_EQ       = 5'd12;
    localparam logic [KIND_W-1:0] K_NUMBER      = 5'd13;
    localparam logic [KIND_W-1:0] K_SEMI        = 5'd14;
    localparam logic [KIND_W-1:0] K_COLON       = 5'd15;
    localparam logic [KIND_W-1:0] K_IMPORTANT   = 5'd16;
    localparam logic [KIND_W-1:0] K_IDENT       = 5'd17;
    localparam logic [KIND_W-1:0] K_STRING      = 5'd18;
    localparam logic [KIND_W-1:0] K_STAR        = 5'd19;
    localparam logic [KIND_W-1:0] K_WS          = 5'd20;
    localparam logic [KIND_W-1:0] K_EOF         = 5'd21;
    localparam logic [KIND_W-1:0] K_UNKNOWN     = 5'd22;
    localparam logic [KIND_W-1:0] K_OPEN_STRING = 5'd23;

    localparam logic [KWI_W-1:0] KW_TAIL_LEN = 4'd9;
    localparam logic [LEN_W-1:0] KW_FULL_LEN = 12'd10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic              sat;
    } tok_t;

    typedef struct packed {
        tok_t [GRP_MAX-1:0] toks;
        logic [CNT_W-1:0]   cnt;
    } grp_t;

    function automatic logic is_alpha(input logic [BYTE_W-1:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic [BYTE_W-1:0] kw_char(input logic [KWI_W-1:0] i);
        logic [BYTE_W-1:0] c;
        unique case (i)
            4'd0:    c = "i";
            4'd1:    c = "m";
            4'd2:    c = "p";
            4'd3:    c = "o";
            4'd4:    c = "r";
            4'd5:    c = "t";
            4'd6:    c = "a";
            4'd7:    c = "n";
            default: c = "t";
        endcase
        return c;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(input logic [BYTE_W-1:0] p);
        logic [KIND_W-1:0] k;
        unique case (p)
            "*":     k = K_STAR_EQ;
            "~":     k = K_TILDE_EQ;
            "^":     k = K_CARET_EQ;
            "|":     k = K_PIPE_EQ;
            "$":     k = K_DOLLAR_EQ;
            default: k = K_EQ_EQ;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [BYTE_W-1:0] p);
        logic [KIND_W-1:0] k;
        unique case (p)
            "=":     k = K_EQ;
            "*":     k = K_STAR;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind,
                                    input logic [POS_W-1:0] start,
                                    input logic [LEN_W-1:0] length,
                                    input logic sat);
        tok_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.sat    = sat;
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== src/sst_if.sv =====
// Handshake channels of the tokenizer: source bytes in, tokens out.
`default_nettype none
interface sst_in_if import sst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface sst_out_if import sst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [POS_W-1:0]  token_start;
    logic [LEN_W-1:0]  token_length;
    logic              length_saturated;
    logic              run_last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output length_saturated, output run_last,
                    input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input length_saturated, input run_last,
                  output ready);
endinterface
`default_nettype wire

// ===== src/sst_front.sv =====
// Lexer front end: one byte per cycle unless q_full; builds the group it causes.
`default_nettype none
module sst_front import sst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sst_in_if.sink    byte_ch,
    input  wire logic q_full,
    output logic      q_push,
    output grp_t      q_grp
);

    logic [MODE_W-1:0] mode_reg,  mode_next;
    logic [BYTE_W-1:0] quote_reg, quote_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [LEN_W-1:0]  len_reg,   len_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [BYTE_W-1:0] pend_reg,  pend_next;
    logic [KWI_W-1:0]  kwi_reg,   kwi_next;
    logic              over_reg,  over_next;

    logic [BYTE_W-1:0]  b;
    logic               last;
    logic               used;
    logic               accept;
    logic [KWI_W-1:0]   ki;
    logic [POS_W-1:0]   bang_id_start;
    logic [CNT_W-1:0]   cnt;
    tok_t [GRP_MAX-1:0] toks;

    assign byte_ch.ready = !q_full;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign b             = byte_ch.in_byte;
    assign last          = byte_ch.end_of_input;

    always_comb
    begin
        mode_next     = mode_reg;
        quote_next    = quote_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        pend_next     = pend_reg;
        kwi_next      = kwi_reg;
        over_next     = over_reg;
        used          = 1'b0;
        cnt           = '0;
        toks          = '0;
        ki            = (kwi_reg < KW_TAIL_LEN) ? kwi_reg : (KW_TAIL_LEN - 4'd1);
        bang_id_start = (start_reg < POS_CAP) ? (start_reg + 16'd1) : POS_CAP;

        // keyword match after '!'
        if (mode_reg == M_BANG)
        begin
            if (b == kw_char(ki))
            begin
                kwi_next = ki + 4'd1;
                if (kwi_next == KW_TAIL_LEN)
                begin
                    toks[cnt[1:0]] = mk_tok(K_IMPORTANT, start_reg, KW_FULL_LEN, 1'b0);
                    cnt            = cnt + 3'd1;
                    mode_next      = M_IDLE;
                    kwi_next       = '0;
                end
                used = 1'b1;
            end
            else
            begin
                toks[cnt[1:0]] = mk_tok(K_UNKNOWN, start_reg, 12'd1, 1'b0);
                cnt            = cnt + 3'd1;
                mode_next      = M_IDLE;
                if (kwi_reg != '0)
                begin
                    mode_next  = M_IDENT;
                    start_next = bang_id_start;
                    len_next   = LEN_W'(kwi_reg);
                    over_next  = 1'b0;
                end
                kwi_next = '0;
            end
        end

        // continue or close the open token
        if (!used)
        begin
            unique case (mode_next)
                M_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b) || (b == "-"))
                    begin
                        if (len_next < LEN_CAP)
                            len_next = len_next + 12'd1;
                        else
                            over_next = 1'b1;
                        used = 1'b1;
                    end
                    else
                    begin
                        toks[cnt[1:0]] = mk_tok(K_IDENT, start_next, len_next, over_next);
                        cnt            = cnt + 3'd1;
                        mode_next      = M_IDLE;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(b))
                    begin
                        if (len_next < LEN_CAP)
                            len_next = len_next + 12'd1;
                        else
                            over_next = 1'b1;
                        used = 1'b1;
                    end
                    else
                    begin
                        toks[cnt[1:0]] = mk_tok(K_NUMBER, start_next, len_next, over_next);
                        cnt            = cnt + 3'd1;
                        mode_next      = M_IDLE;
                    end
                end
                M_STRING:
                begin
                    if (len_next < LEN_CAP)
                        len_next = len_next + 12'd1;
                    else
                        over_next = 1'b1;
                    if (b == quote_next)
                    begin
                        toks[cnt[1:0]] = mk_tok(K_STRING, start_next, len_next, over_next);
                        cnt            = cnt + 3'd1;
                        mode_next      = M_IDLE;
                    end
                    used = 1'b1;
                end
                M_OP:
                begin
                    if (b == "=")
                    begin
                        toks[cnt[1:0]] = mk_tok(pair_kind(pend_next), start_next, 12'd2, 1'b0);
                        used           = 1'b1;
                    end
                    else
                    begin
                        toks[cnt[1:0]] = mk_tok(single_kind(pend_next), start_next, 12'd1, 1'b0);
                    end
                    cnt       = cnt + 3'd1;
                    mode_next = M_IDLE;
                end
                default:
                begin
                end
            endcase
        end

        // open a new token on this byte
        if (!used)
        begin
            priority if (is_space(b))
            begin
                toks[cnt[1:0]] = mk_tok(K_WS, pos_reg, 12'd1, 1'b0);
                cnt            = cnt + 3'd1;
            end
            else if ((b == "\"") || (b == "'"))
            begin
                mode_next  = M_STRING;
                start_next = pos_reg;
                len_next   = 12'd1;
                over_next  = 1'b0;
                quote_next = b;
            end
            else if (is_alpha(b))
            begin
                mode_next  = M_IDENT;
                start_next = pos_reg;
                len_next   = 12'd1;
                over_next  = 1'b0;
            end
            else if (is_digit(b))
            begin
                mode_next  = M_NUMBER;
                start_next = pos_reg;
                len_next   = 12'd1;
                over_next  = 1'b0;
            end
            else
            begin
                unique case (b)
                    "#":
                    begin
                        toks[cnt[1:0]] = mk_tok(K_HASH, pos_reg, 12'd1, 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                    ".":
                    begin
                        toks[cnt[1:0]] = mk_tok(K_DOT, pos_reg, 12'd1, 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                    "[":
                    begin
                        toks[cnt[1:0]] = mk_tok(K_LBRACK, pos_reg, 12'd1, 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                    "]":
                    begin
                        toks[cnt[1:0]] = mk_tok(K_RBRACK, pos_reg, 12'd1, 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                    "{":
                    begin
                        toks[cnt[1:0]] = mk_tok(K_LBRACE, pos_reg, 12'd1, 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                    "}":
                    begin
                        toks[cnt[1:0]] = mk_tok(K_RBRACE, pos_reg, 12'd1, 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                    ";":
                    begin
                        toks[cnt[1:0]] = mk_tok(K_SEMI, pos_reg, 12'd1, 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                    ":":
                    begin
                        toks[cnt[1:0]] = mk_tok(K_COLON, pos_reg, 12'd1, 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                    "=", "*", "|", "~", "$", "^":
                    begin
                        mode_next  = M_OP;
                        pend_next  = b;
                        start_next = pos_reg;
                    end
                    "!":
                    begin
                        mode_next  = M_BANG;
                        kwi_next   = '0;
                        start_next = pos_reg;
                    end
                    default:
                    begin
                        toks[cnt[1:0]] = mk_tok(K_UNKNOWN, pos_reg, 12'd1, 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                endcase
            end
        end

        if (pos_reg < POS_CAP)
            pos_next = pos_reg + 16'd1;

        // flush pending token, add EOF, restart
        if (last)
        begin
            unique case (mode_next)
                M_IDENT:
                begin
                    toks[cnt[1:0]] = mk_tok(K_IDENT, start_next, len_next, over_next);
                    cnt            = cnt + 3'd1;
                end
                M_NUMBER:
                begin
                    toks[cnt[1:0]] = mk_tok(K_NUMBER, start_next, len_next, over_next);
                    cnt            = cnt + 3'd1;
                end
                M_STRING:
                begin
                    toks[cnt[1:0]] = mk_tok(K_OPEN_STRING, start_next, len_next, over_next);
                    cnt            = cnt + 3'd1;
                end
                M_OP:
                begin
                    toks[cnt[1:0]] = mk_tok(single_kind(pend_next), start_next, 12'd1, 1'b0);
                    cnt            = cnt + 3'd1;
                end
                M_BANG:
                begin
                    toks[cnt[1:0]] = mk_tok(K_UNKNOWN, start_next, 12'd1, 1'b0);
                    cnt            = cnt + 3'd1;
                    if (kwi_next != '0)
                    begin
                        toks[cnt[1:0]] = mk_tok(K_IDENT,
                                                (start_next < POS_CAP) ?
                                                (start_next + 16'd1) : POS_CAP,
                                                LEN_W'(kwi_next), 1'b0);
                        cnt            = cnt + 3'd1;
                    end
                end
                default:
                begin
                end
            endcase
            toks[cnt[1:0]] = mk_tok(K_EOF, pos_next, 12'd0, 1'b0);
            cnt            = cnt + 3'd1;
            mode_next      = M_IDLE;
            quote_next     = '0;
            start_next     = '0;
            len_next       = '0;
            pos_next       = '0;
            pend_next      = '0;
            kwi_next       = '0;
            over_next      = 1'b0;
        end
    end

    assign q_push     = accept && (cnt != '0);
    assign q_grp.toks = toks;
    assign q_grp.cnt  = cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            quote_reg <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            pend_reg  <= '0;
            kwi_reg   <= '0;
            over_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            pend_reg  <= pend_next;
            kwi_reg   <= kwi_next;
            over_reg  <= over_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/sst_queue.sv =====
// Short queue of token groups between the lexer front end and the output stage.
`default_nettype none
module sst_queue import sst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire grp_t push_grp,
    input  wire logic pop,
    output grp_t      head_grp,
    output logic      full,
    output logic      empty
);

    grp_t              slots [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_grp = slots[rd_reg];

    always_comb
    begin
        wr_next    = do_push ? (wr_reg + 1'b1) : wr_reg;
        rd_next    = do_pop ? (rd_reg + 1'b1) : rd_reg;
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/sst_back.sv =====
// Output stage: holds a token group; sends one token per cycle while ready.
`default_nettype none
module sst_back import sst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire grp_t q_grp,
    input  wire logic q_empty,
    output logic      q_pop,
    sst_out_if.source token_ch
);

    grp_t              cur_reg, cur_next;
    logic [1:0]        idx_reg, idx_next;
    logic              have_reg, have_next;
    logic              fire;
    logic              last_tok;
    logic              load;
    tok_t              tok;

    assign fire     = token_ch.valid && token_ch.ready;
    assign last_tok = (({1'b0, idx_reg} + 3'd1) == cur_reg.cnt);
    assign load     = !have_reg || (fire && last_tok);
    assign q_pop    = load && !q_empty;
    assign tok      = cur_reg.toks[idx_reg];

    always_comb
    begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        have_next = have_reg;
        if (load)
        begin
            have_next = !q_empty;
            cur_next  = q_grp;
            idx_next  = '0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    assign token_ch.valid            = have_reg;
    assign token_ch.token_kind       = tok.kind;
    assign token_ch.token_start      = tok.start;
    assign token_ch.token_length     = tok.length;
    assign token_ch.length_saturated = tok.sat;
    assign token_ch.run_last         = last_tok;

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            have_reg <= have_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/style_sheet_tokenizer.sv =====
// Top level of the style-sheet tokenizer: front end, group queue and output stage.
// Tokens pass a group queue slot and the output stage register before they are sent.
// One byte per cycle while the queue has room; the output stage sends one token per cycle
//   while ready is high, so a byte that causes k tokens (k up to 4) needs k transfers.
// The four-entry group queue lets the front end keep taking bytes while tokens drain.
// Reset: asynchronous, clears lexer state and byte offset, empties the queue.
`default_nettype none
`include "assert_macros.svh"
module style_sheet_tokenizer import sst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sst_in_if.sink    byte_ch,
    sst_out_if.source token_ch
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    grp_t q_in;
    grp_t q_head;
    logic byte_fire;
    logic eof_out;

    assign byte_fire = byte_ch.valid && byte_ch.ready;
    assign eof_out   = token_ch.valid && (token_ch.token_kind == K_EOF);

    sst_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_grp   (q_in)
    );

    sst_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_grp (q_in),
        .pop      (q_pop),
        .head_grp (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    sst_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_grp    (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .token_ch (token_ch)
    );

    `SST_ASSERT_NOW(a_push_has_room, q_push, !q_full)
    `SST_ASSERT_NOW(a_final_byte_pushes, byte_fire && byte_ch.end_of_input, q_push)
    `SST_ASSERT_NOW(a_eof_ends_run, eof_out, token_ch.run_last)
    `SST_ASSERT_NOW(a_eof_empty, eof_out, (token_ch.token_length == '0) && !token_ch.length_saturated)

endmodule
`default_nettype wire

// ===== test/style_sheet_tokenizer_tb.sv =====
// Testbench for the style-sheet tokenizer: directed and random text checked against a lexer model.
`timescale 1ns / 1ps
module style_sheet_tokenizer_tb import sst_pkg::*;
();

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic              sat;
        logic              last;
    } token_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              eoi;
        logic              typed;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
    } opening_row_t;

    localparam int OPENING_ROWS = 25;
    localparam int RANDOM_ITEMS = 240;
    localparam logic [71:0] KEYWORD_TAIL = "important";

    localparam opening_row_t OPENING [OPENING_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, K_UNKNOWN, 16'd0, 12'd1},
        '{8'hFF, 1'b0, 1'b1, K_UNKNOWN, 16'd1, 12'd1},
        '{"#", 1'b0, 1'b1, K_HASH, 16'd2, 12'd1},
        '{".", 1'b0, 1'b1, K_DOT, 16'd3, 12'd1},
        '{"{", 1'b0, 1'b1, K_LBRACE, 16'd4, 12'd1},
        '{"}", 1'b0, 1'b1, K_RBRACE, 16'd5, 12'd1},
        '{"[", 1'b0, 1'b1, K_LBRACK, 16'd6, 12'd1},
        '{"]", 1'b0, 1'b1, K_RBRACK, 16'd7, 12'd1},
        '{";", 1'b0, 1'b1, K_SEMI, 16'd8, 12'd1},
        '{":", 1'b0, 1'b1, K_COLON, 16'd9, 12'd1},
        '{8'h09, 1'b0, 1'b1, K_WS, 16'd10, 12'd1},
        '{"*", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"=", 1'b0, 1'b1, K_STAR_EQ, 16'd11, 12'd2},
        '{"|", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"x", 1'b0, 1'b1, K_UNKNOWN, 16'd13, 12'd1},
        '{"9", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"-", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"!", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"i", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"m", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{";", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"'", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"a", 1'b0, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"\"", 1'b1, 1'b0, K_HASH, 16'd0, 12'd0},
        '{"7", 1'b1, 1'b0, K_HASH, 16'd0, 12'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    sst_in_if  byte_ch ();
    sst_out_if token_ch ();

    style_sheet_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .token_ch (token_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [MODE_W-1:0] lx_mode;
    logic [BYTE_W-1:0] lx_quote;
    logic [POS_W-1:0]  lx_start;
    logic [LEN_W-1:0]  lx_len;
    logic [POS_W-1:0]  lx_pos;
    logic [BYTE_W-1:0] lx_op;
    int                lx_kw;
    bit                lx_over;

    token_t step_tokens[$];
    token_t pending_tokens[$];
    int     errors;
    bit     no_gaps;
    int     stall_left;
    int     ready_roll;

    initial
    begin
        #1500000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit letter(input logic [BYTE_W-1:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit digit(input logic [BYTE_W-1:0] b);
        return b >= "0" && b <= "9";
    endfunction

    task automatic clear_lexer();
        lx_mode  = M_IDLE;
        lx_quote = '0;
        lx_start = '0;
        lx_len   = '0;
        lx_pos   = '0;
        lx_op    = '0;
        lx_kw    = 0;
        lx_over  = 1'b0;
    endtask

    task automatic add_token(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] start,
                             input logic [LEN_W-1:0] length, input bit sat);
        if (step_tokens.size() < GRP_MAX)
            step_tokens.push_back('{kind, start, length, sat, 1'b0});
    endtask

    task automatic open_token(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] start);
        lx_mode  = mode;
        lx_start = start;
        lx_len   = 1;
        lx_over  = 1'b0;
    endtask

    task automatic close_open(input logic [KIND_W-1:0] kind);
        add_token(kind, lx_start, lx_len, lx_over);
        lx_mode = M_IDLE;
    endtask

    task automatic close_single_op();
        logic [KIND_W-1:0] kind;
        kind = (lx_op == "=") ? K_EQ : (lx_op == "*") ? K_STAR : K_UNKNOWN;
        add_token(kind, lx_start, 1, 1'b0);
        lx_mode = M_IDLE;
    endtask

    task automatic grow_token();
        if (lx_len < LEN_CAP)
            lx_len++;
        else
            lx_over = 1'b1;
    endtask

    // '!' becomes unknown; the keyword letters already matched open an identifier
    task automatic keyword_break();
        add_token(K_UNKNOWN, lx_start, 1, 1'b0);
        lx_mode = M_IDLE;
        if (lx_kw > 0)
        begin
            open_token(M_IDENT, (lx_start < POS_CAP) ? lx_start + 1'b1 : POS_CAP);
            lx_len = LEN_W'(lx_kw);
        end
    endtask

    task automatic begin_token(input logic [BYTE_W-1:0] b);
        if (b == " " || (b >= 8'd9 && b <= 8'd13))
            add_token(K_WS, lx_pos, 1, 1'b0);
        else if (b == "\"" || b == "'")
        begin
            open_token(M_STRING, lx_pos);
            lx_quote = b;
        end
        else if (letter(b))
            open_token(M_IDENT, lx_pos);
        else if (digit(b))
            open_token(M_NUMBER, lx_pos);
        else
        begin
            case (b)
                "#": add_token(K_HASH, lx_pos, 1, 1'b0);
                ".": add_token(K_DOT, lx_pos, 1, 1'b0);
                "[": add_token(K_LBRACK, lx_pos, 1, 1'b0);
                "]": add_token(K_RBRACK, lx_pos, 1, 1'b0);
                "{": add_token(K_LBRACE, lx_pos, 1, 1'b0);
                "}": add_token(K_RBRACE, lx_pos, 1, 1'b0);
                ";": add_token(K_SEMI, lx_pos, 1, 1'b0);
                ":": add_token(K_COLON, lx_pos, 1, 1'b0);
                "=", "*", "|", "~", "$", "^":
                begin
                    lx_mode  = M_OP;
                    lx_op    = b;
                    lx_start = lx_pos;
                end
                "!":
                begin
                    lx_mode  = M_BANG;
                    lx_kw    = 0;
                    lx_start = lx_pos;
                end
                default: add_token(K_UNKNOWN, lx_pos, 1, 1'b0);
            endcase
        end
    endtask

    task automatic lex_step(input logic [BYTE_W-1:0] b, input bit eoi);
        bit used;
        int idx;
        logic [KIND_W-1:0] kind;
        used = 1'b0;
        step_tokens.delete();
        if (lx_mode == M_BANG)
        begin
            idx = (lx_kw < 9) ? lx_kw : 8;
            if (b == KEYWORD_TAIL[71 - 8 * idx -: 8])
            begin
                lx_kw = idx + 1;
                if (lx_kw == 9)
                begin
                    add_token(K_IMPORTANT, lx_start, KW_FULL_LEN, 1'b0);
                    lx_mode = M_IDLE;
                    lx_kw   = 0;
                end
                used = 1'b1;
            end
            else
            begin
                keyword_break();
                lx_kw = 0;
            end
        end
        if (!used)
        begin
            case (lx_mode)
                M_IDENT:
                    if (letter(b) || digit(b) || b == "-")
                    begin
                        grow_token();
                        used = 1'b1;
                    end
                    else
                        close_open(K_IDENT);
                M_NUMBER:
                    if (digit(b))
                    begin
                        grow_token();
                        used = 1'b1;
                    end
                    else
                        close_open(K_NUMBER);
                M_STRING:
                begin
                    grow_token();
                    if (b == lx_quote)
                        close_open(K_STRING);
                    used = 1'b1;
                end
                M_OP:
                    if (b == "=")
                    begin
                        case (lx_op)
                            "*":     kind = K_STAR_EQ;
                            "~":     kind = K_TILDE_EQ;
                            "^":     kind = K_CARET_EQ;
                            "|":     kind = K_PIPE_EQ;
                            "$":     kind = K_DOLLAR_EQ;
                            default: kind = K_EQ_EQ;
                        endcase
                        add_token(kind, lx_start, 2, 1'b0);
                        lx_mode = M_IDLE;
                        used = 1'b1;
                    end
                    else
                        close_single_op();
                default: ;
            endcase
        end
        if (!used)
            begin_token(b);
        if (lx_pos < POS_CAP)
            lx_pos++;
        if (eoi)
        begin
            case (lx_mode)
                M_IDENT:  close_open(K_IDENT);
                M_NUMBER: close_open(K_NUMBER);
                M_STRING: close_open(K_OPEN_STRING);
                M_OP:     close_single_op();
                M_BANG:
                begin
                    keyword_break();
                    if (lx_mode == M_IDENT)
                        close_open(K_IDENT);
                end
                default: ;
            endcase
            add_token(K_EOF, lx_pos, 0, 1'b0);
            clear_lexer();
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
    endtask

    task automatic send_item(input logic [BYTE_W-1:0] b, input bit eoi,
                             input bit use_typed, input token_t typed_tok);
        int roll;
        roll = $urandom_range(0, 99);
        if (!no_gaps && roll >= 70)
        begin
            byte_ch.valid <= 1'b0;
            if (roll < 96)
                repeat ($urandom_range(1, 3)) @(posedge clk);
            else
                repeat ($urandom_range(10, 40)) @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.in_byte      <= b;
        byte_ch.end_of_input <= eoi;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        lex_step(b, eoi);
        if (use_typed)
            pending_tokens.push_back(typed_tok);
        else
            foreach (step_tokens[k])
                pending_tokens.push_back(step_tokens[k]);
    endtask

    task automatic hold_until_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic take_token();
        token_t want;
        if (pending_tokens.size() == 0)
        begin
            errors++;
            $display("%0t: token expected none, got kind %0d start %0d length %0d",
                     $time, token_ch.token_kind, token_ch.token_start,
                     token_ch.token_length);
        end
        else
        begin
            want = pending_tokens.pop_front();
            check_field("token_kind", want.kind, token_ch.token_kind);
            check_field("token_start", want.start, token_ch.token_start);
            check_field("token_length", want.length, token_ch.token_length);
            check_field("length_saturated", want.sat, token_ch.length_saturated);
            check_field("run_last", want.last, token_ch.run_last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (token_ch.valid && token_ch.ready)
                take_token();
            if (no_gaps || stall_left == 0)
            begin
                token_ch.ready <= 1'b1;
                stall_left = 0;
                ready_roll = $urandom_range(0, 99);
                if (!no_gaps && ready_roll < 12)
                    stall_left = $urandom_range(1, 3);
                else if (!no_gaps && ready_roll < 14)
                    stall_left = $urandom_range(10, 40);
            end
            else
            begin
                token_ch.ready <= 1'b0;
                stall_left--;
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] frag[$];
        logic [BYTE_W-1:0] q;
        string punct;
        string ops;
        int sent;
        int n;
        int r;
        token_t typed_tok;
        punct = "#.[]{};:";
        ops   = "=*|~$^";
        errors     = 0;
        no_gaps    = 1'b0;
        stall_left = 0;
        byte_ch.valid        = 1'b0;
        byte_ch.in_byte      = '0;
        byte_ch.end_of_input = 1'b0;
        token_ch.ready       = 1'b0;
        rst_n = 1'b0;
        clear_lexer();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < OPENING_ROWS; i++)
        begin
            typed_tok = '{OPENING[i].kind, OPENING[i].start, OPENING[i].length, 1'b0, 1'b1};
            send_item(OPENING[i].b, OPENING[i].eoi, OPENING[i].typed, typed_tok);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            frag.delete();
            case ($urandom_range(0, 9))
                0:
                begin
                    frag.push_back($urandom_range(0, 1) ? 8'($urandom_range(97, 122))
                                                        : 8'($urandom_range(65, 90)));
                    repeat ($urandom_range(0, 6))
                    begin
                        r = $urandom_range(0, 9);
                        if (r < 3)
                            frag.push_back(8'($urandom_range(97, 122)));
                        else if (r < 6)
                            frag.push_back(8'($urandom_range(65, 90)));
                        else if (r < 9)
                            frag.push_back(8'($urandom_range(48, 57)));
                        else
                            frag.push_back("-");
                    end
                end
                1:
                    repeat ($urandom_range(1, 5))
                        frag.push_back(8'($urandom_range(48, 57)));
                2:
                begin
                    q = $urandom_range(0, 1) ? "\"" : "'";
                    frag.push_back(q);
                    repeat ($urandom_range(0, 6))
                        frag.push_back(8'($urandom_range(32, 126)));
                    if ($urandom_range(0, 7) != 0)
                        frag.push_back(q);
                end
                3:
                begin
                    frag.push_back(ops[$urandom_range(0, 5)]);
                    if ($urandom_range(0, 2) != 0)
                        frag.push_back("=");
                end
                4:
                begin
                    frag.push_back("!");
                    n = $urandom_range(0, 8);
                    for (int k = 0; k < n; k++)
                        frag.push_back(KEYWORD_TAIL[71 - 8 * k -: 8]);
                end
                5:
                begin
                    frag.push_back("!");
                    for (int k = 0; k < 9; k++)
                        frag.push_back(KEYWORD_TAIL[71 - 8 * k -: 8]);
                end
                6:
                    frag.push_back(punct[$urandom_range(0, 7)]);
                7:
                begin
                    r = $urandom_range(0, 6);
                    frag.push_back((r < 5) ? 8'(9 + r) : " ");
                end
                8:
                    frag.push_back(8'($urandom_range(0, 255)));
                default:
                    frag.push_back(8'($urandom_range(32, 126)));
            endcase
            foreach (frag[k])
            begin
                send_item(frag[k], $urandom_range(0, 24) == 0, 1'b0, typed_tok);
                sent++;
                if (sent == 60)
                    no_gaps = 1'b1;
                if (sent == 110)
                    no_gaps = 1'b0;
                if (sent == 180)
                    hold_until_drained();
            end
        end
        send_item(";", 1'b1, 1'b0, typed_tok);
        hold_until_drained();

        // end the text on a partial keyword
        no_gaps = 1'b1;
        send_item(" ", 1'b0, 1'b0, typed_tok);
        send_item("!", 1'b0, 1'b0, typed_tok);
        send_item("i", 1'b0, 1'b0, typed_tok);
        send_item("x", 1'b1, 1'b0, typed_tok);
        no_gaps = 1'b0;

        byte_ch.valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
